/* design/tpts_pkg.sv */
// ----------------------------------------------------------------------------
// tpts_pkg: shared types and constants for the tick priority task scheduler
// Default sizes, opcodes, sequencer states and the per-cell command word.
// ----------------------------------------------------------------------------
`default_nettype none

package tpts_pkg;

  localparam int NUM_TASKS_DEF     = 8;
  localparam int COUNTER_BITS_DEF  = 10;
  localparam int PRIORITY_BITS_DEF = 8;

  // op field codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // command strobes sent to one task cell
  typedef struct packed {
    logic load;
    logic refresh;
    logic dec;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* design/tick_priority_task_scheduler_core.sv */
// ----------------------------------------------------------------------------
// tick_priority_task_scheduler_core: counter/priority task scheduler
// Task table held in a chain of cells; a sequencer drives loads, ticks,
// refresh and picks, and returns one result word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries one word: op selects a
//   timer tick or a load of one table entry (task_index, load_*). Output
//   channel (result_valid / result_stall) returns exactly one word per input
//   word: the running task, its counter and the switched/refreshed/
//   all_priorities_zero flags.
//   A load or a tick that does not reschedule goes straight to the emit
//   state. A reschedule runs the scan chain of NUM_TASKS-1 cells for one
//   pass, or for a second pass when a refresh is forced; the chain length
//   sets the length of a pass.
//   One word at a time: item_stall is high while a word is in work, and
//   the next word is taken once the sequencer is back in idle after the
//   result is loaded.
//   The next word is accepted while the previous result still waits.
//   Reset (synchronous, rst high): all entries cleared, idle (task 0) runs,
//   no result pending.
//   If the receiver stalls, the result word holds and the sequencer waits
//   with its next result until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_priority_task_scheduler_core #(
  parameter int NUM_TASKS     = tpts_pkg::NUM_TASKS_DEF,
  parameter int COUNTER_BITS  = tpts_pkg::COUNTER_BITS_DEF,
  parameter int PRIORITY_BITS = tpts_pkg::PRIORITY_BITS_DEF,
  localparam int IDX_BITS     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
  input  wire                      clk,
  input  wire                      rst,
  // input words
  input  wire                      item_valid,
  output logic                     item_stall,
  input  wire                      op,
  input  wire [IDX_BITS-1:0]       task_index,
  input  wire [COUNTER_BITS-1:0]   load_counter,
  input  wire [PRIORITY_BITS-1:0]  load_priority,
  input  wire                      load_present,
  input  wire                      load_runnable,
  // result words
  output logic                     result_valid,
  input  wire                      result_stall,
  output logic [IDX_BITS-1:0]      current_task,
  output logic                     switched,
  output logic [COUNTER_BITS-1:0]  current_counter,
  output logic                     refreshed,
  output logic                     all_priorities_zero
);

  localparam logic [IDX_BITS-1:0] SCAN_LAST = IDX_BITS'(NUM_TASKS - 1);

  tpts_pkg::state_t state, state_next;

  logic [IDX_BITS-1:0]     running;
  logic [IDX_BITS-1:0]     prev;
  logic                    refreshed_r;
  logic                    zero_r;
  logic [IDX_BITS-1:0]     wait_cnt;

  // chain wiring: entry 0 is the empty head word, entry i is cell i output
  logic                    chain_found [NUM_TASKS];
  logic [COUNTER_BITS-1:0] chain_cnt   [NUM_TASKS];
  logic [IDX_BITS-1:0]     chain_idx   [NUM_TASKS];
  logic [COUNTER_BITS-1:0] cell_cnt    [NUM_TASKS];
  tpts_pkg::cell_cmd_t     cmd         [1:NUM_TASKS-1];

  logic                    accept;
  logic                    load_go;
  logic                    dec_go;
  logic                    refresh_go;
  logic                    scan_done;
  logic                    emit;
  logic [COUNTER_BITS-1:0] run_cnt;
  logic                    end_found;
  logic [COUNTER_BITS-1:0] end_cnt;
  logic [IDX_BITS-1:0]     end_idx;

  assign chain_found[0] = 1'b0;
  assign chain_cnt[0]   = '0;
  assign chain_idx[0]   = '0;
  assign cell_cnt[0]    = '0;   // idle counter never changes

  genvar gi;
  generate
    for (gi = 1; gi < NUM_TASKS; gi++) begin : g_cell
      // task_index 0 and indexes past the table match no cell
      assign cmd[gi] = '{
        load:    load_go && (task_index == IDX_BITS'(gi)),
        refresh: refresh_go,
        dec:     dec_go && (running == IDX_BITS'(gi))
      };

      tpts_cell #(
        .CELL_INDEX    (gi),
        .IDX_BITS      (IDX_BITS),
        .COUNTER_BITS  (COUNTER_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
        .clk            (clk),
        .rst            (rst),
        .cmd            (cmd[gi]),
        .load_counter   (load_counter),
        .load_priority  (load_priority),
        .load_present   (load_present),
        .load_runnable  (load_runnable),
        .scan_found_in  (chain_found[gi-1]),
        .scan_cnt_in    (chain_cnt[gi-1]),
        .scan_idx_in    (chain_idx[gi-1]),
        .scan_found_out (chain_found[gi]),
        .scan_cnt_out   (chain_cnt[gi]),
        .scan_idx_out   (chain_idx[gi]),
        .counter        (cell_cnt[gi])
      );
    end
  endgenerate

  assign end_found = chain_found[NUM_TASKS-1];
  assign end_cnt   = chain_cnt[NUM_TASKS-1];
  assign end_idx   = chain_idx[NUM_TASKS-1];
  assign run_cnt   = cell_cnt[running];

  // sequencer: next state and strobes
  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    accept     = 1'b0;
    load_go    = 1'b0;
    dec_go     = 1'b0;
    refresh_go = 1'b0;
    emit       = 1'b0;
    scan_done  = (wait_cnt == SCAN_LAST);
    unique case (state)
      tpts_pkg::S_IDLE: begin
        item_stall = 1'b0;
        accept     = item_valid;
        if (item_valid) begin
          if (op == tpts_pkg::OP_LOAD) begin
            load_go    = 1'b1;
            state_next = tpts_pkg::S_EMIT;
          end else begin
            // running task with counter left: count down
            dec_go  = (running != '0) && (run_cnt != '0);
            // reschedule when idle runs or counter is / becomes zero
            if ((running == '0) || (run_cnt[COUNTER_BITS-1:1] == '0)) begin
              state_next = tpts_pkg::S_SCAN;
            end else begin
              state_next = tpts_pkg::S_EMIT;
            end
          end
        end
      end
      tpts_pkg::S_SCAN: begin
        if (scan_done) begin
          if (end_found && (end_cnt == '0) && !refreshed_r) begin
            refresh_go = 1'b1;   // second pass after refresh
          end else begin
            state_next = tpts_pkg::S_EMIT;
          end
        end
      end
      tpts_pkg::S_EMIT: begin
        emit = !result_valid || !result_stall;
        if (emit) begin
          state_next = tpts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tpts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pick bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= '0;
      prev        <= '0;
      refreshed_r <= 1'b0;
      zero_r      <= 1'b0;
      wait_cnt    <= '0;
    end else begin
      if (accept) begin
        prev        <= running;
        refreshed_r <= 1'b0;
        zero_r      <= 1'b0;
        wait_cnt    <= '0;
      end else if (state == tpts_pkg::S_SCAN) begin
        if (scan_done) begin
          wait_cnt <= '0;
          if (!end_found) begin
            running <= '0;
          end else if (end_cnt != '0) begin
            running <= end_idx;
          end else if (!refreshed_r) begin
            refreshed_r <= 1'b1;
          end else begin
            // refresh gave nothing: force idle
            running <= '0;
            zero_r  <= 1'b1;
          end
        end else begin
          wait_cnt <= wait_cnt + IDX_BITS'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      current_task        <= running;
      switched            <= (running != prev);
      current_counter     <= run_cnt;
      refreshed           <= refreshed_r;
      all_priorities_zero <= zero_r;
    end
  end

endmodule

`default_nettype wire

/* design/tpts_cell.sv */
// ----------------------------------------------------------------------------
// tpts_cell: one task entry of the scheduler chain
// Holds present/runnable/counter/priority for one task and forwards the
// running best-candidate word to its upper neighbor every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpts_cell #(
  parameter int CELL_INDEX    = 1,
  parameter int IDX_BITS      = 3,
  parameter int COUNTER_BITS  = tpts_pkg::COUNTER_BITS_DEF,
  parameter int PRIORITY_BITS = tpts_pkg::PRIORITY_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  tpts_pkg::cell_cmd_t          cmd,
  input  wire [COUNTER_BITS-1:0]       load_counter,
  input  wire [PRIORITY_BITS-1:0]      load_priority,
  input  wire                          load_present,
  input  wire                          load_runnable,
  input  wire                          scan_found_in,
  input  wire [COUNTER_BITS-1:0]       scan_cnt_in,
  input  wire [IDX_BITS-1:0]           scan_idx_in,
  output logic                         scan_found_out,
  output logic [COUNTER_BITS-1:0]      scan_cnt_out,
  output logic [IDX_BITS-1:0]          scan_idx_out,
  output logic [COUNTER_BITS-1:0]      counter
);

  localparam int SUM_BITS =
    ((COUNTER_BITS > PRIORITY_BITS) ? COUNTER_BITS : PRIORITY_BITS) + 1;
  localparam logic [SUM_BITS-1:0] CNT_MAX = SUM_BITS'({COUNTER_BITS{1'b1}});

  logic                     present;
  logic                     runnable;
  logic [PRIORITY_BITS-1:0] priority_q;
  logic [SUM_BITS-1:0]      refresh_sum;
  logic [COUNTER_BITS-1:0]  refresh_val;
  logic                     eligible;
  logic                     take;

  // counter/2 + priority, saturated
  always_comb begin
    refresh_sum = SUM_BITS'(counter >> 1) + SUM_BITS'(priority_q);
    if (refresh_sum > CNT_MAX) begin
      refresh_val = {COUNTER_BITS{1'b1}};
    end else begin
      refresh_val = refresh_sum[COUNTER_BITS-1:0];
    end
  end

  // >= so that ties go to the higher index (chain runs upward)
  assign eligible = present && runnable;
  assign take     = eligible && (!scan_found_in || (counter >= scan_cnt_in));

  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= 1'b0;
      runnable   <= 1'b0;
      counter    <= '0;
      priority_q <= '0;
    end else begin
      priority case (1'b1)
        cmd.load: begin
          present    <= load_present;
          runnable   <= load_runnable;
          counter    <= load_counter;
          priority_q <= load_priority;
        end
        cmd.refresh: begin
          if (present) begin
            counter <= refresh_val;
          end
        end
        cmd.dec: begin
          counter <= counter - COUNTER_BITS'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_found_out <= 1'b0;
      scan_cnt_out   <= '0;
      scan_idx_out   <= '0;
    end else begin
      scan_found_out <= scan_found_in || eligible;
      if (take) begin
        scan_cnt_out <= counter;
        scan_idx_out <= IDX_BITS'(CELL_INDEX);
      end else begin
        scan_cnt_out <= scan_cnt_in;
        scan_idx_out <= scan_idx_in;
      end
    end
  end

endmodule

`default_nettype wire

/* dv/tick_priority_task_scheduler_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_priority_task_scheduler_core_tb: self-checking bench for the scheduler
// Loads task entries and sends timer ticks under random sender gaps and
// receiver stalls; a scoreboard predicts every result word and checks it.
// ----------------------------------------------------------------------------

module tick_priority_task_scheduler_core_tb;

  localparam int NT      = tpts_pkg::NUM_TASKS_DEF;
  localparam int CW      = tpts_pkg::COUNTER_BITS_DEF;
  localparam int PW      = tpts_pkg::PRIORITY_BITS_DEF;
  localparam int IW      = $clog2(NT);
  localparam int CNT_MAX = (1 << CW) - 1;
  localparam int PRI_MAX = (1 << PW) - 1;
  localparam int RANDOM_WORDS = 1250;

  // one result word as the block reports it
  typedef struct packed {
    logic [IW-1:0] task_id;
    logic          sw;
    logic [CW-1:0] cnt;
    logic          refr;
    logic          zero;
  } sched_result_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_BLINK
  } stall_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the task table, predicts one word per input word
  // --------------------------------------------------------------------------
  class sched_scoreboard;
    bit            present [NT];
    bit            runnable[NT];
    logic [CW-1:0] counter [NT];
    logic [PW-1:0] prio    [NT];
    logic [IW-1:0] running;
    sched_result_t expected[$];
    int            errors;

    function new();
      for (int i = 0; i < NT; i++) begin
        present[i]  = 1'b0;
        runnable[i] = 1'b0;
        counter[i]  = '0;
        prio[i]     = '0;
      end
      running = '0;
      errors  = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // largest counter among present runnable tasks, ties to the higher index
    function void pick_top(output bit found, output logic [IW-1:0] idx,
                           output logic [CW-1:0] cnt);
      found = 1'b0;
      idx   = '0;
      cnt   = '0;
      for (int i = NT - 1; i >= 1; i--) begin
        if (present[i] && runnable[i] && (!found || counter[i] > cnt)) begin
          found = 1'b1;
          cnt   = counter[i];
          idx   = IW'(i);
        end
      end
    endfunction

    // counter/2 + priority, clamped at the counter width
    function void refresh_counters();
      logic [CW:0] sum;
      for (int i = 1; i < NT; i++) begin
        if (present[i]) begin
          sum = (counter[i] >> 1) + prio[i];
          counter[i] = (sum > CNT_MAX) ? CNT_MAX[CW-1:0] : sum[CW-1:0];
        end
      end
    endfunction

    function void reschedule(output bit refr, output bit zero);
      bit            found;
      logic [IW-1:0] idx;
      logic [CW-1:0] cnt;
      refr = 1'b0;
      zero = 1'b0;
      pick_top(found, idx, cnt);
      if (!found) begin
        running = '0;
        return;
      end
      if (cnt == 0) begin
        refresh_counters();
        refr = 1'b1;
        pick_top(found, idx, cnt);
        // nothing gained from the refresh: fall back to idle
        if (cnt == 0) begin
          zero = 1'b1;
          idx  = '0;
        end
      end
      running = idx;
    endfunction

    // an input word was accepted: update the table and queue its result
    function void note_word(logic w_op, logic [IW-1:0] w_idx, logic [CW-1:0] w_cnt,
                            logic [PW-1:0] w_prio, logic w_pres, logic w_run);
      logic [IW-1:0] prev;
      bit            refr;
      bit            zero;
      sched_result_t e;
      prev = running;
      refr = 1'b0;
      zero = 1'b0;
      if (w_op == tpts_pkg::OP_LOAD) begin
        if (w_idx != 0 && w_idx < NT) begin
          counter[w_idx]  = w_cnt;
          prio[w_idx]     = w_prio;
          present[w_idx]  = w_pres;
          runnable[w_idx] = w_run;
        end
      end else if (running == 0) begin
        reschedule(refr, zero);
      end else if (counter[running] == 0) begin
        reschedule(refr, zero);
      end else begin
        counter[running] = counter[running] - 1'b1;
        if (counter[running] == 0) reschedule(refr, zero);
      end
      e.task_id = running;
      e.sw      = (running != prev);
      e.cnt     = counter[running];
      e.refr    = refr;
      e.zero    = zero;
      expected.push_back(e);
    endfunction

    function void field_check(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    // a result word was accepted: compare against the oldest prediction
    function void check_word(sched_result_t got);
      sched_result_t e;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected: expected none, actual %h",
                 $time, got);
        return;
      end
      e = expected.pop_front();
      field_check("current_task", e.task_id, got.task_id);
      field_check("switched", e.sw, got.sw);
      field_check("current_counter", e.cnt, got.cnt);
      field_check("refreshed", e.refr, got.refr);
      field_check("all_priorities_zero", e.zero, got.zero);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic          clk           = 1'b0;
  logic          rst           = 1'b1;
  logic          item_valid    = 1'b0;
  logic          item_stall;
  logic          op            = tpts_pkg::OP_TICK;
  logic [IW-1:0] task_index    = '0;
  logic [CW-1:0] load_counter  = '0;
  logic [PW-1:0] load_priority = '0;
  logic          load_present  = 1'b0;
  logic          load_runnable = 1'b0;
  logic          result_valid;
  logic          result_stall  = 1'b0;
  logic [IW-1:0] current_task;
  logic          switched;
  logic [CW-1:0] current_counter;
  logic          refreshed;
  logic          all_priorities_zero;

  sched_scoreboard sb = new();

  int burst_left = 0;   // words left in the current sender burst
  int words_done = 0;   // words that act on the table (ignored loads excluded)

  tick_priority_task_scheduler_core dut (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (item_valid),
    .item_stall         (item_stall),
    .op                 (op),
    .task_index         (task_index),
    .load_counter       (load_counter),
    .load_priority      (load_priority),
    .load_present       (load_present),
    .load_runnable      (load_runnable),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .current_task       (current_task),
    .switched           (switched),
    .current_counter    (current_counter),
    .refreshed          (refreshed),
    .all_priorities_zero(all_priorities_zero)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern switches at random between free, light, heavy and
  // a blink that follows bit 2 of the mode countdown.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = RX_FREE;
  int          mode_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_mode   <= RX_FREE;
      mode_left    <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        RX_FREE:  result_stall <= 1'b0;
        RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
        default:  result_stall <= mode_left[2];
      endcase
    end
  end

  // Outputs and stall only move at the rising edge, so the negedge view is
  // exactly what the next edge will accept.
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_word({current_task, switched, current_counter, refreshed,
                     all_priorities_zero});
  end

  // --------------------------------------------------------------------------
  // Sender tasks: each starts and returns in the time step of a rising edge
  // --------------------------------------------------------------------------
  task automatic send_word(input logic w_op, input logic [IW-1:0] w_idx,
                           input logic [CW-1:0] w_cnt, input logic [PW-1:0] w_prio,
                           input logic w_pres, input logic w_run);
    int gap;
    // burst boundary: optional idle gap, then a new burst length
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    op            <= w_op;
    task_index    <= w_idx;
    load_counter  <= w_cnt;
    load_priority <= w_prio;
    load_present  <= w_pres;
    load_runnable <= w_run;
    item_valid    <= 1'b1;
    @(negedge clk);
    while (item_stall) @(negedge clk);
    sb.note_word(w_op, w_idx, w_cnt, w_prio, w_pres, w_run);
    if (!(w_op == tpts_pkg::OP_LOAD && w_idx == 0)) words_done++;
    @(posedge clk);
  endtask

  task automatic load_entry(input logic [IW-1:0] idx, input logic [CW-1:0] cnt,
                            input logic [PW-1:0] pr, input logic pres, input logic run);
    send_word(tpts_pkg::OP_LOAD, idx, cnt, pr, pres, run);
  endtask

  // load fields of a tick carry junk; the block must ignore them
  task automatic tick_word();
    send_word(tpts_pkg::OP_TICK, IW'($urandom_range(0, NT - 1)),
              CW'($urandom_range(0, CNT_MAX)), PW'($urandom_range(0, PRI_MAX)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // hold the sender off until every predicted word has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // small counters and priorities keep reschedules and refreshes frequent
  function automatic logic [CW-1:0] rand_count();
    return ($urandom_range(0, 9) == 0) ? CW'($urandom_range(0, CNT_MAX))
                                       : CW'($urandom_range(0, 12));
  endfunction

  function automatic logic [PW-1:0] rand_prio();
    return ($urandom_range(0, 9) == 0) ? PW'($urandom_range(0, PRI_MAX))
                                       : PW'($urandom_range(0, 6));
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    tick_word();                                  // idle, empty table: stays idle
    load_entry(0, CW'(CNT_MAX), PW'(PRI_MAX), 1'b1, 1'b1);  // load of idle is ignored
    load_entry(7, CW'(CNT_MAX), PW'(PRI_MAX), 1'b1, 1'b1);
    load_entry(1, 0, 0, 1'b0, 1'b0);
    load_entry(2, 10'd512, 8'd128, 1'b1, 1'b0);
    load_entry(4, 3, 1, 1'b1, 1'b1);
    load_entry(6, 3, 2, 1'b1, 1'b1);              // ties with 4, higher index wins
    load_entry(5, 0, 0, 1'b0, 1'b1);
    load_entry(3, 10'h155, 8'h55, 1'b1, 1'b1);
    tick_word();                                  // idle reschedules: picks 7
    tick_word();                                  // 7 decrements
    load_entry(7, 1, PW'(PRI_MAX), 1'b1, 1'b0);   // running entry reloaded, not runnable
    tick_word();                                  // 7 hits zero: picks 3
    load_entry(3, 0, 0, 1'b1, 1'b1);              // running entry reloaded to zero
    tick_word();                                  // zero counter: reschedule, tie 4/6 -> 6
    load_entry(4, 0, 0, 1'b1, 1'b1);
    load_entry(6, 0, 0, 1'b1, 1'b1);
    tick_word();                                  // refresh gains nothing: idle forced
    load_entry(5, 0, 7, 1'b1, 1'b1);
    tick_word();                                  // refresh lifts 5 to 7: picks 5
    tick_word();
    wait_drained();

    // --- random: mostly load-then-tick runs, plus noise and corner setups ---
    words_done = 0;
    while (words_done < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        n = $urandom_range(1, 5);
        repeat (n)
          load_entry(IW'($urandom_range(1, NT - 1)), rand_count(), rand_prio(),
                     $urandom_range(0, 7) != 0, $urandom_range(0, 4) != 0);
        n = $urandom_range(3, 25);
        repeat (n) tick_word();
      end else if (pick < 80) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 1))
            tick_word();
          else
            load_entry(IW'($urandom_range(0, NT - 1)), CW'($urandom_range(0, CNT_MAX)),
                       PW'($urandom_range(0, PRI_MAX)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        end
      end else if (pick < 92) begin
        // overwrite whatever is running now (idle load is a no-op)
        load_entry(sb.running, rand_count(), rand_prio(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        n = $urandom_range(1, 8);
        repeat (n) tick_word();
      end else begin
        // drain every counter and priority to zero
        for (int i = 1; i < NT; i++)
          load_entry(IW'(i), 0, 0, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
        n = $urandom_range(1, 4);
        repeat (n) tick_word();
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);   // catch stray words after the last one
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
